>>> design/deq_pkg.sv
// Package for the double-ended queue block.
// Holds the operation and status codes, controller states and the
// command bundle from controller to datapath. No dependencies.
package deq_pkg;

  // Width of the operation field
  localparam int unsigned FuncWidth   = 3;
  // Width of the status field
  localparam int unsigned StatusWidth = 2;

  // Operation codes; codes 5..7 behave as a query
  typedef enum logic [FuncWidth-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_QUERY      = 3'd4
  } deq_op_e;

  // Result status codes
  typedef enum logic [StatusWidth-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } deq_status_e;

  // Controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_READ,
    S_OUT
  } deq_state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic load_item;  // capture the accepted transaction
    logic exec;       // update store, head and count
    logic read;       // read front and back entries
    logic load_out;   // load the result register
  } deq_cmd_t;

endpackage

>>> design/deq_ctrl.sv
// Controller state machine for the double-ended queue.
// Sequences accept, update, store read and result load.
// Depends on deq_pkg.
module deq_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output deq_pkg::deq_cmd_t cmd_o
);
  import deq_pkg::*;

  deq_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  // Result register can take a new result
  assign out_free = !out_valid_q || !out_stall_i;

  // State and result-valid registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d         = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = S_READ;
      end
      S_READ: begin
        cmd_o.read = 1'b1;
        state_d    = S_OUT;
      end
      S_OUT: begin
        // keep reading so the read data stays current while stalled
        cmd_o.read = 1'b1;
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

>>> design/deq_datapath.sv
// Datapath of the double-ended queue: circular word store, head pointer,
// entry count, end-word cache and result register.
// Depends on deq_pkg.
module deq_datapath #(
  parameter int unsigned DEPTH      = 1024,
  parameter int unsigned DATA_WIDTH = 32,
  localparam int unsigned PW        = $clog2(DEPTH),
  localparam int unsigned CW        = $clog2(DEPTH + 1)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  deq_pkg::deq_cmd_t             cmd_i,
  input  logic [deq_pkg::FuncWidth-1:0] func_i,
  input  logic signed [DATA_WIDTH-1:0]  push_value_i,
  output logic signed [DATA_WIDTH-1:0]  popped_value_o,
  output logic                          popped_valid_o,
  output logic [deq_pkg::StatusWidth-1:0] status_o,
  output logic [CW-1:0]                 entry_count_o,
  output logic                          is_empty_o,
  output logic signed [DATA_WIDTH-1:0]  front_value_o,
  output logic signed [DATA_WIDTH-1:0]  back_value_o
);
  import deq_pkg::*;

  localparam logic [PW-1:0] LastSlot  = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FullCount = CW'(DEPTH);
  localparam logic [CW:0]   DepthWide = (CW + 1)'(DEPTH);

  // Word store
  logic [DATA_WIDTH-1:0] mem_q [DEPTH];

  // Captured transaction
  logic [FuncWidth-1:0]  op_q;
  logic [DATA_WIDTH-1:0] word_q;

  // Ring state
  logic [PW-1:0] head_q, head_d;
  logic [CW-1:0] count_q, count_d;

  // End-word cache, valid while count is nonzero
  logic [DATA_WIDTH-1:0] front_q, back_q;
  logic [DATA_WIDTH-1:0] rd_front_q, rd_back_q;

  // Per-transaction result held until the result register loads
  logic [DATA_WIDTH-1:0] popped_q, popped_d;
  logic                  pvalid_q, pvalid_d;
  deq_status_e           stat_q, stat_d;

  logic                  we;
  logic [PW-1:0]         waddr;
  logic [PW-1:0]         head_dec, head_inc, push_slot, tail_slot;
  logic [CW:0]           push_sum, tail_sum;
  logic                  is_full, no_entries;

  // Pointer arithmetic, wrapped at DEPTH
  always_comb begin
    is_full    = (count_q == FullCount);
    no_entries = (count_q == '0);
    head_dec   = (head_q == '0) ? LastSlot : head_q - PW'(1);
    head_inc   = (head_q == LastSlot) ? '0 : head_q + PW'(1);
    push_sum   = (CW + 1)'(head_q) + (CW + 1)'(count_q);
    push_slot  = (push_sum >= DepthWide) ? PW'(push_sum - DepthWide) : PW'(push_sum);
    // back slot of the current state: head + count - 1
    tail_sum   = (CW + 1)'(head_q) + (CW + 1)'(count_q) - (CW + 1)'(1);
    tail_slot  = (tail_sum >= DepthWide) ? PW'(tail_sum - DepthWide) : PW'(tail_sum);
  end

  // Operation decode
  always_comb begin
    head_d   = head_q;
    count_d  = count_q;
    popped_d = '0;
    pvalid_d = 1'b0;
    stat_d   = ST_OK;
    we       = 1'b0;
    waddr    = push_slot;
    unique case (op_q)
      OP_PUSH_FRONT: begin
        if (is_full) begin
          stat_d = ST_FULL;
        end else begin
          head_d  = head_dec;
          waddr   = head_dec;
          we      = 1'b1;
          count_d = count_q + CW'(1);
        end
      end
      OP_PUSH_BACK: begin
        if (is_full) begin
          stat_d = ST_FULL;
        end else begin
          we      = 1'b1;
          count_d = count_q + CW'(1);
        end
      end
      OP_POP_FRONT: begin
        if (no_entries) begin
          stat_d = ST_EMPTY;
        end else begin
          popped_d = front_q;
          pvalid_d = 1'b1;
          head_d   = head_inc;
          count_d  = count_q - CW'(1);
        end
      end
      OP_POP_BACK: begin
        if (no_entries) begin
          stat_d = ST_EMPTY;
        end else begin
          popped_d = back_q;
          pvalid_d = 1'b1;
          count_d  = count_q - CW'(1);
        end
      end
      default: ;  // query and unused codes change nothing
    endcase
  end

  // Ring control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
    end else if (cmd_i.exec) begin
      head_q  <= head_d;
      count_q <= count_d;
    end
  end

  // Store write and two-address registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && we) begin
      mem_q[waddr] <= word_q;
    end
    if (cmd_i.read) begin
      rd_front_q <= mem_q[head_q];
      rd_back_q  <= mem_q[tail_slot];
    end
  end

  // Transaction capture and per-transaction result
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      op_q   <= func_i;
      word_q <= push_value_i;
    end
    if (cmd_i.exec) begin
      popped_q <= popped_d;
      pvalid_q <= pvalid_d;
      stat_q   <= stat_d;
    end
  end

  // Result register and end-word cache
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      front_q        <= rd_front_q;
      back_q         <= rd_back_q;
      popped_value_o <= popped_q;
      popped_valid_o <= pvalid_q;
      status_o       <= stat_q;
      entry_count_o  <= count_q;
      is_empty_o     <= no_entries;
      front_value_o  <= no_entries ? '0 : rd_front_q;
      back_value_o   <= no_entries ? '0 : rd_back_q;
    end
  end

endmodule

>>> design/double_ended_queue.sv
// Double-ended queue of signed words in a circular store.
// One transaction at a time: the next is accepted only after the controller
// sequence of capture, store update, two-port store read and result load.
// Reset clears head pointer, count and control state; store contents are not cleared.
// Depends on deq_pkg, deq_ctrl and deq_datapath.
module double_ended_queue #(
  parameter int unsigned DEPTH      = 1024,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [deq_pkg::FuncWidth-1:0]   func_i,
  input  logic signed [DATA_WIDTH-1:0]    push_value_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic signed [DATA_WIDTH-1:0]    popped_value_o,
  output logic                            popped_valid_o,
  output logic [deq_pkg::StatusWidth-1:0] status_o,
  output logic [$clog2(DEPTH + 1)-1:0]    entry_count_o,
  output logic                            is_empty_o,
  output logic signed [DATA_WIDTH-1:0]    front_value_o,
  output logic signed [DATA_WIDTH-1:0]    back_value_o
);
  import deq_pkg::*;

  deq_cmd_t cmd;

  // Sequencer
  deq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .cmd_o      (cmd)
  );

  // Store, pointers and result register
  deq_datapath #(
    .DEPTH     (DEPTH),
    .DATA_WIDTH(DATA_WIDTH)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .func_i        (func_i),
    .push_value_i  (push_value_i),
    .popped_value_o(popped_value_o),
    .popped_valid_o(popped_valid_o),
    .status_o      (status_o),
    .entry_count_o (entry_count_o),
    .is_empty_o    (is_empty_o),
    .front_value_o (front_value_o),
    .back_value_o  (back_value_o)
  );

endmodule
